// ----- hdl/line_assembler_double_buffer_core_macros.svh -----
// assertion macros shared by the line assembler modules
`ifndef LINE_ASSEMBLER_DOUBLE_BUFFER_CORE_MACROS_SVH
`define LINE_ASSEMBLER_DOUBLE_BUFFER_CORE_MACROS_SVH

// same-cycle implication, checked on clk, quiet during rst
`define LADB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, quiet during rst
`define LADB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ladb_pkg.sv -----
// shared types and constants for the line assembler
package ladb_pkg;

  localparam int LINE_MAX = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = IDX_W + 1;

  localparam logic [CNT_W-1:0] LINE_MAX_CNT = CNT_W'(LINE_MAX);

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_LINE = 2'd1;
  localparam logic [1:0] STATUS_NOT_EN  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_OVERFLOW,
    OP_FREEZE,
    OP_RESP,
    OP_START
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] resp_status;
    logic       streaming;
    logic       stream_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rx_enable;
    logic line_waiting;
    logic accum_empty;
    logic accum_full;
    logic is_term;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/ladb_ctrl.sv -----
// controller state machine: decodes accepted items and sequences the read stream
`include "line_assembler_double_buffer_core_macros.svh"

module ladb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic                rx_error,
  input  ladb_pkg::dp_stat_t  st,
  output ladb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    STREAM
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   stream_done;

  assign in_ready    = (state == IDLE) && st.out_free;
  assign accept      = in_valid && in_ready;
  assign stream_done = (state == STREAM) && st.out_free && st.at_end;

  always_comb begin
    state_next      = state;
    cmd.op          = ladb_pkg::OP_NONE;
    cmd.resp_status = ladb_pkg::STATUS_OK;
    cmd.streaming   = (state == STREAM);
    cmd.stream_load = 1'b0;
    unique case (state)
      IDLE: begin
        if (accept) begin
          if (command == ladb_pkg::CMD_READ) begin
            if (!st.rx_enable) begin
              cmd.op          = ladb_pkg::OP_RESP;
              cmd.resp_status = ladb_pkg::STATUS_NOT_EN;
            end else if (!st.line_waiting) begin
              cmd.op          = ladb_pkg::OP_RESP;
              cmd.resp_status = ladb_pkg::STATUS_NO_LINE;
            end else begin
              cmd.op     = ladb_pkg::OP_START;
              state_next = STREAM;
            end
          end else if (st.rx_enable && !rx_error) begin
            if (st.is_term) begin
              if (!st.accum_empty) cmd.op = ladb_pkg::OP_FREEZE;
            end else if (st.accum_full) begin
              cmd.op = ladb_pkg::OP_OVERFLOW;
            end else begin
              cmd.op = ladb_pkg::OP_APPEND;
            end
          end
        end
      end
      STREAM: begin
        cmd.stream_load = st.out_free;
        if (stream_done) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LADB_ASSERT_NEXT(a_stream_ends, stream_done, state == IDLE, "stream did not end")
  `LADB_ASSERT_NEXT(a_read_starts, cmd.op == ladb_pkg::OP_START, state == STREAM, "no stream")
  `LADB_ASSERT_NOW(a_stream_has_line, state == STREAM, st.line_waiting, "stream with no line")

endmodule

// ----- hdl/ladb_dpath.sv -----
// datapath: line banks, counters, enable register and result register
`include "line_assembler_double_buffer_core_macros.svh"

module ladb_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic [7:0]          rx_byte,
  input  ladb_pkg::ctrl_cmd_t cmd,
  output ladb_pkg::dp_stat_t  st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [1:0]          status,
  output logic [7:0]          line_byte,
  output logic [6:0]          line_length,
  output logic                truncated,
  output logic                last
);

  // two banks of line storage, roles swap on every freeze
  logic [7:0] mem [0:(2**ladb_pkg::ADDR_W)-1];
  logic [7:0] rd_data;
  logic [ladb_pkg::ADDR_W-1:0] rd_addr;
  logic [ladb_pkg::IDX_W-1:0]  rd_idx;

  logic                        rx_enable;
  logic                        acc_bank;
  logic [ladb_pkg::CNT_W-1:0]  accum_count;
  logic                        overflow_mark;
  logic [ladb_pkg::CNT_W-1:0]  ready_count;
  logic                        ready_truncated;
  logic                        line_waiting;
  logic [ladb_pkg::IDX_W-1:0]  ptr;
  logic                        out_free;
  logic                        out_load;
  logic                        freeze_op;

  assign freeze_op = (cmd.op == ladb_pkg::OP_FREEZE);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = freeze_op || (cmd.op == ladb_pkg::OP_RESP) || cmd.stream_load;

  assign st.rx_enable    = rx_enable;
  assign st.line_waiting = line_waiting;
  assign st.accum_empty  = (accum_count == '0);
  assign st.accum_full   = (accum_count == ladb_pkg::LINE_MAX_CNT);
  assign st.is_term      = (rx_byte == ladb_pkg::BYTE_CR) || (rx_byte == ladb_pkg::BYTE_LF);
  assign st.at_end       = ({1'b0, ptr} == (ready_count - ladb_pkg::CNT_W'(1)));
  assign st.out_free     = out_free;

  // ready bank is the one not accumulating
  always_comb begin
    if (!cmd.streaming)       rd_idx = '0;
    else if (cmd.stream_load) rd_idx = ptr + ladb_pkg::IDX_W'(1);
    else                      rd_idx = ptr;
    rd_addr = {~acc_bank, rd_idx};
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ladb_pkg::OP_APPEND) begin
      mem[{acc_bank, accum_count[ladb_pkg::IDX_W-1:0]}] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable       <= 1'b0;
      acc_bank        <= 1'b0;
      accum_count     <= '0;
      overflow_mark   <= 1'b0;
      ready_count     <= '0;
      ready_truncated <= 1'b0;
      line_waiting    <= 1'b0;
      ptr             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        rx_enable <= cfg_data;
        if (cfg_data && !rx_enable) begin
          accum_count   <= '0;
          overflow_mark <= 1'b0;
          line_waiting  <= 1'b0;
        end
      end
      case (cmd.op)
        ladb_pkg::OP_APPEND:   accum_count <= accum_count + ladb_pkg::CNT_W'(1);
        ladb_pkg::OP_OVERFLOW: overflow_mark <= 1'b1;
        ladb_pkg::OP_FREEZE: begin
          acc_bank        <= ~acc_bank;
          ready_count     <= accum_count;
          ready_truncated <= overflow_mark;
          line_waiting    <= 1'b1;
          accum_count     <= '0;
          overflow_mark   <= 1'b0;
        end
        ladb_pkg::OP_START: ptr <= '0;
        default: ;
      endcase
      if (cmd.stream_load) begin
        ptr <= ptr + ladb_pkg::IDX_W'(1);
        if (st.at_end) begin
          line_waiting    <= 1'b0;
          ready_truncated <= 1'b0;
        end
      end
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.stream_load) begin
      kind        <= ladb_pkg::KIND_READ;
      status      <= ladb_pkg::STATUS_OK;
      line_byte   <= rd_data;
      line_length <= ready_count;
      truncated   <= ready_truncated;
      last        <= st.at_end;
    end else if (freeze_op) begin
      kind        <= ladb_pkg::KIND_NOTICE;
      status      <= ladb_pkg::STATUS_OK;
      line_byte   <= '0;
      line_length <= accum_count;
      truncated   <= overflow_mark;
      last        <= 1'b1;
    end else if (cmd.op == ladb_pkg::OP_RESP) begin
      kind        <= ladb_pkg::KIND_READ;
      status      <= cmd.resp_status;
      line_byte   <= '0;
      line_length <= '0;
      truncated   <= 1'b0;
      last        <= 1'b1;
    end
  end

  `LADB_ASSERT_NOW(a_no_overwrite, out_load, out_free, "result register overwritten")
  `LADB_ASSERT_NOW(a_count_bound, 1'b1, accum_count <= ladb_pkg::LINE_MAX_CNT, "count over max")
  `LADB_ASSERT_NEXT(a_freeze_sets_line, freeze_op, line_waiting && |ready_count, "no line")

endmodule

// ----- hdl/line_assembler_double_buffer_core.sv -----
// top level of the receive line assembler with double-buffered line storage
//
// usage:
// - in channel (in_valid/in_ready): command 0 carries a received byte with its
//   error flag, command 1 asks for the waiting line
// - out channel (out_valid/out_ready): line-ready notices and read responses,
//   each transfer carries kind, status, line_byte, line_length, truncated, last
// - cfg channel (cfg_valid/cfg_ready): writes rx_enable; always ready; it is to
//   be written only while no item is in flight, which the user must ensure as
//   the block does not; enabling clears the partial line and any waiting line
// - byte items produce no result except a terminator after a non-empty line,
//   whose notice is in the result register the cycle after the transfer
// - a refused read or empty read answers with one result, in the result register the cycle after the transfer
// - a read of a waiting line moves its first byte through the registered
//   storage read and then the result register, then one byte per cycle while
//   the receiver takes them; the storage read port sets that rate
// - a new item is taken each cycle the block is not streaming and the result
//   register is empty or being taken; a stalled receiver holds the stream and
//   the input side
// - reset (rst, synchronous) disables the receiver and empties both lines;
//   storage contents are left as they are, no clearing pass is needed

module line_assembler_double_buffer_core (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  logic       rx_error,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [1:0] status,
  output logic [7:0] line_byte,
  output logic [6:0] line_length,
  output logic       truncated,
  output logic       last,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       rx_enable
);

  ladb_pkg::ctrl_cmd_t cmd;
  ladb_pkg::dp_stat_t  st;

  // configuration writes land immediately in the datapath register
  assign cfg_ready = 1'b1;

  // sequencing: item decode and read stream
  ladb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .rx_error (rx_error),
    .st       (st),
    .cmd      (cmd)
  );

  // storage banks, counters and result register
  ladb_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (rx_enable),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .status      (status),
    .line_byte   (line_byte),
    .line_length (line_length),
    .truncated   (truncated),
    .last        (last)
  );

endmodule
